// ----- sv/gaoa_pkg.sv -----
// Package: shared types and constants for the grass ambient occlusion accumulator.
package gaoa_pkg;
   localparam int unsigned ONE_Q16 = 65536;
   localparam int unsigned ONE_Q15 = 32768;

   typedef enum logic [2:0] {
      CSR_INV_RADIUS = 3'd0,
      CSR_INV_SIZE   = 3'd1,
      CSR_COLOR_R    = 3'd2,
      CSR_COLOR_G    = 3'd3,
      CSR_COLOR_B    = 3'd4
   } csr_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_KD,
      ST_KS,
      ST_KA,
      ST_T1,
      ST_T2,
      ST_ACC,
      ST_SH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } sqrt_ctl_type;
endpackage

// ----- sv/grass_ambient_occlusion_accumulator_core.sv -----
// Top level of the grass ambient occlusion accumulator core.
//
// Channel | Direction | Payload
// req_    | in        | tdata: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, blade_size;
//         |           | tuser: action; tlast: last
// rsp_    | out       | tdata: shade_r, shade_g, shade_b
// csr_    | in        | index (3 bits), data (32 bits)
//
// A start transaction without last leaves the block idle. A grass transaction keeps the
// block busy after acceptance: ST_SQ sums the squared distances and the normal dot
// product, ST_SQRT waits for the bit-serial square root (load, two bits per iteration,
// hand over the root) and ST_KD to ST_ACC form the three terms and the sum. A last item
// then fills the three shade channels in ST_SH and raises the result valid in ST_OUT.
// Reset is synchronous and active high and clears the vertex, the sum and the
// registers. A stalled result holds in the output register; no new transaction
// is taken until the shade has been delivered.
module grass_ambient_occlusion_accumulator_core
   import gaoa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [175:0]  req_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, blade_size
   input  logic          req_tuser,   // action
   input  logic          req_tlast,   // last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [47:0]   rsp_tdata,   // shade_r, shade_g, shade_b
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);
   state_type st_ff, st_in;
   logic [31:0] inv_r_ff, inv_s_ff;
   logic [15:0] col_ff [3];
   logic signed [31:0] vp_ff [3];
   logic signed [15:0] vn_ff [3];
   logic [16:0] sum_ff;
   logic signed [31:0] gp_ff [3];
   logic signed [15:0] gn_ff [3];
   logic [31:0] size_ff;
   logic last_ff;
   logic [1:0]  idx_ff;
   logic [65:0] sq_ff;
   logic signed [34:0] dot_ff;
   logic [16:0] kd_ff, ks_ff;
   logic [22:0] ka_ff;
   logic [39:0] t_ff;
   logic [47:0] out_ff;
   logic        ovalid_ff;
   logic        sq_start;
   sqrt_ctl_type sctl;
   logic [31:0] root;

   logic signed [32:0] dpos;
   logic [32:0] apos;
   logic [65:0] sqsq;
   logic [63:0] rprod, sprod;
   logic [16:0] cc;
   logic [32:0] sprd;
   logic [40:0] acc;

   assign req_tready = (st_ff == ST_IDLE) && !ovalid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;
   // The root starts in the first cycle of its wait state, once the squared sum is complete.
   assign sq_start   = (st_ff == ST_SQRT) && !sctl.busy && !sctl.done;

   gaoa_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .radicand(sq_ff[63:0]), .ctl(sctl), .root(root)
   );

   always_comb begin
      dpos  = 33'(gp_ff[idx_ff]) - 33'(vp_ff[idx_ff]);
      apos  = dpos[32] ? 33'(-dpos) : 33'(dpos);
      sqsq  = 66'(apos[31:0]) * 66'(apos[31:0]) + (apos[32] ? 66'h1_0000_0000_0000_0000 : 66'd0);
      rprod = 64'(root) * 64'(inv_r_ff);
      sprod = 64'(size_ff) * 64'(inv_s_ff);
      cc    = (col_ff[idx_ff] > 16'(ONE_Q15)) ? 17'd0 : 17'(ONE_Q15) - 17'(col_ff[idx_ff]);
      sprd  = 33'(sum_ff) * 33'(cc[15:0]) + (cc[16] ? (33'(sum_ff) << 15) : 33'd0);
      acc   = 41'(sum_ff) + 41'(t_ff);
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req_tvalid && req_tready)
                     st_in = req_tuser ? ST_SQ : (req_tlast ? ST_SH : ST_IDLE);
         ST_SQ:   if (idx_ff == 2'd2) st_in = ST_SQRT;
         ST_SQRT: if (sctl.done) st_in = ST_KD;
         ST_KD:   st_in = ST_KS;
         ST_KS:   st_in = ST_KA;
         ST_KA:   st_in = ST_T1;
         ST_T1:   st_in = ST_T2;
         ST_T2:   st_in = ST_ACC;
         ST_ACC:  st_in = last_ff ? ST_SH : ST_IDLE;
         ST_SH:   if (idx_ff == 2'd2) st_in = ST_OUT;
         ST_OUT:  st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ovalid_ff <= 1'b0; idx_ff <= '0;
         inv_r_ff <= '0; inv_s_ff <= '0; sum_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            col_ff[i] <= '0; vp_ff[i] <= '0; vn_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_INV_RADIUS: inv_r_ff <= csr_data;
               CSR_INV_SIZE:   inv_s_ff <= csr_data;
               CSR_COLOR_R:    col_ff[0] <= csr_data[15:0];
               CSR_COLOR_G:    col_ff[1] <= csr_data[15:0];
               CSR_COLOR_B:    col_ff[2] <= csr_data[15:0];
               default: ;
            endcase
         end
         if (ovalid_ff && rsp_tready) ovalid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               idx_ff <= '0; sq_ff <= '0; dot_ff <= '0; last_ff <= req_tlast;
               if (req_tvalid && req_tready) begin
                  for (int i = 0; i < 3; i++) begin
                     gp_ff[i] <= req_tdata[32*i +: 32];
                     gn_ff[i] <= req_tdata[96 + 16*i +: 16];
                  end
                  size_ff <= req_tdata[175:144];
                  if (!req_tuser) begin
                     sum_ff <= '0;
                     for (int i = 0; i < 3; i++) begin
                        vp_ff[i] <= req_tdata[32*i +: 32];
                        vn_ff[i] <= req_tdata[96 + 16*i +: 16];
                     end
                  end
               end
            end
            ST_SQ: begin
               sq_ff  <= sq_ff + sqsq;
               dot_ff <= dot_ff + 35'(32'(gn_ff[idx_ff]) * 32'(vn_ff[idx_ff]));
               idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            end
            ST_KD: kd_ff <= (sq_ff[65:64] != 2'b00 || rprod[63:16] >= 48'(ONE_Q16))
                            ? 17'd0 : 17'(ONE_Q16) - 17'(rprod[31:16]);
            ST_KS: ks_ff <= (sprod[63:16] >= 48'(ONE_Q16)) ? 17'(ONE_Q16) : 17'(sprod[31:16]);
            // The dot term is not limited above, so it keeps every bit of the shifted sum.
            ST_KA: ka_ff <= (dot_ff > 0) ? dot_ff[34:12] : 23'd0;
            ST_T1: t_ff  <= 40'(ks_ff) * 40'(ka_ff);
            ST_T2: t_ff  <= 40'((57'(t_ff) * 57'(kd_ff)) >> 32);
            ST_ACC: begin
               sum_ff <= (acc >= 41'(ONE_Q16)) ? 17'(ONE_Q16) : acc[16:0];
               idx_ff <= '0;
            end
            ST_SH: begin
               out_ff[16*idx_ff +: 16] <= (inv_r_ff == 0 || inv_s_ff == 0) ? 16'(ONE_Q15)
                  : 16'(ONE_Q15) - 16'((sprd + 33'd32768) >> 16);
               idx_ff <= (idx_ff == 2'd2) ? 2'd0 : idx_ff + 2'd1;
            end
            ST_OUT: ovalid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // The accumulated sum never exceeds one.
   a_sum_sat: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= 17'(ONE_Q16)) else $error("occlusion sum above one");
   // No transaction is taken while a result waits.
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   // The root unit only runs during its wait state.
   a_sqrt: assert property (@(posedge clock) disable iff (reset)
      sctl.busy |-> st_ff == ST_SQRT) else $error("square root out of step");
endmodule

// ----- sv/gaoa_isqrt.sv -----
// Bit-serial integer square root: two radicand bits consumed per cycle.
module gaoa_isqrt
   import gaoa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   radicand,
   output sqrt_ctl_type  ctl,
   output logic [31:0]   root
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] x_ff, x_in;
   logic [31:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [65:0] trial;
   logic [65:0] rsh;

   always_comb begin
      rsh    = {rem_ff, x_ff[63:62]};
      trial  = rsh - {32'd0, q_ff, 2'b01};
      rem_in = rem_ff; x_in = x_ff; q_in = q_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         rem_in = '0; x_in = radicand; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[61:0], 2'b00};
         if (!trial[65]) begin
            rem_in = trial[63:0]; q_in = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = rsh[63:0]; q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; x_ff <= x_in; q_ff <= q_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign ctl  = '{start: start, busy: busy_ff, done: done_ff};
   assign root = q_ff;
endmodule

// ----- bench/tb_grass_ambient_occlusion_accumulator_core.sv -----
// Self-checking bench for the grass ambient occlusion accumulator core.
module tb_grass_ambient_occlusion_accumulator_core;
   import gaoa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [175:0]  req_tdata = '0;   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, blade_size
   logic          req_tuser = 1'b0; // action
   logic          req_tlast = 1'b0; // last
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [47:0]   rsp_tdata;        // shade_r, shade_g, shade_b
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [2:0]    csr_index = '0;
   logic [31:0]   csr_data = '0;

   // Action codes carried in tuser.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_GRASS = 1'b1;

   typedef struct packed {
      logic [15:0] b;
      logic [15:0] g;
      logic [15:0] r;
   } shade_type;

   // Shadow copy of the block's registers and query state.
   logic [31:0]        inv_radius_q, inv_size_q;
   logic [15:0]        color_q [3];
   logic signed [63:0] vtx_pos [3];
   logic signed [31:0] vtx_norm [3];
   logic [31:0]        ao_sum;

   shade_type shade_queue [$];
   int        errors = 0;

   grass_ambient_occlusion_accumulator_core u_top (.*);

   always #6 clock = ~clock;

   // Floor square root of a 64-bit value, digit by digit.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= r + bit_v) begin
            x = x - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   // Updates the shadow state for one request and queues a shade if it ends a query.
   task automatic predict_shade(input logic act, input logic [175:0] d, input logic lst);
      logic signed [63:0] p [3];
      logic signed [31:0] n [3];
      logic [63:0]        sq, s, a, kd, ks, ka, ratio;
      logic signed [63:0] dd, dot;
      logic [127:0]       term;
      logic               far;
      logic [63:0]        c, prod;
      shade_type          sh;
      for (int i = 0; i < 3; i++) begin
         p[i] = 64'(signed'(d[32*i +: 32]));
         n[i] = 32'(signed'(d[96 + 16*i +: 16]));
      end
      if (act == ACT_START) begin
         for (int i = 0; i < 3; i++) begin
            vtx_pos[i] = p[i];
            vtx_norm[i] = n[i];
         end
         ao_sum = 0;
      end else begin
         sq = 0; far = 0; dot = 0;
         for (int i = 0; i < 3; i++) begin
            dd = p[i] - vtx_pos[i];
            a = dd < 0 ? -dd : dd;
            s = a * a;
            if (sq + s < sq) far = 1;
            sq = sq + s;
            dot = dot + 64'(n[i]) * 64'(vtx_norm[i]);
         end
         if (far) begin
            kd = 0;
         end else begin
            ratio = (floor_sqrt(sq) * 64'(inv_radius_q)) >> 16;
            if (ratio > ONE_Q16) ratio = ONE_Q16;
            kd = ONE_Q16 - ratio;
         end
         ks = (64'(d[175:144]) * 64'(inv_size_q)) >> 16;
         if (ks > ONE_Q16) ks = ONE_Q16;
         ka = dot > 0 ? 64'(dot) >> 12 : 0;
         term = (128'(ks) * 128'(ka) * 128'(kd)) >> 32;
         if (term > ONE_Q16) term = ONE_Q16;
         ao_sum = ao_sum + 32'(term);
         if (ao_sum > ONE_Q16) ao_sum = ONE_Q16;
      end
      if (lst) begin
         for (int i = 0; i < 3; i++) begin
            c = 64'(ONE_Q15);
            if (inv_radius_q != 0 && inv_size_q != 0) begin
               c = color_q[i] > ONE_Q15 ? ONE_Q15 : color_q[i];
               prod = 64'(ao_sum) * (ONE_Q15 - c);
               c = ONE_Q15 - ((prod + 32768) >> 16);
            end
            sh[16*i +: 16] = c[15:0];
         end
         shade_queue.push_back(sh);
      end
   endtask

   // Sends one request transaction after a random gap; valid stays up until the next
   // falling edge, where the next transaction or an idle step takes over.
   task automatic send_item(input logic act, input logic [175:0] d, input logic lst);
      int gap;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= act;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_shade(act, d, lst);
   endtask

   // Waits until the block is idle, then writes one register.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (shade_queue.size() == 0);
      repeat (60) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_INV_RADIUS) inv_radius_q = val;
      else if (idx == CSR_INV_SIZE) inv_size_q = val;
      else color_q[idx - 2] = val[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [31:0] rad, input logic [31:0] sz,
                           input logic [15:0] cr, input logic [15:0] cg,
                           input logic [15:0] cb);
      write_reg(CSR_INV_RADIUS, rad);
      write_reg(CSR_INV_SIZE, sz);
      write_reg(CSR_COLOR_R, 32'(cr));
      write_reg(CSR_COLOR_G, 32'(cg));
      write_reg(CSR_COLOR_B, 32'(cb));
   endtask

   function automatic logic [175:0] pack_item(input logic [31:0] px, py, pz,
                                              input logic [15:0] nx, ny, nz,
                                              input logic [31:0] sz);
      return {sz, nz, ny, nx, pz, py, px};
   endfunction

   // A random unit-ish normal component, mostly in range, sometimes any 16 bits.
   function automatic logic [15:0] rand_norm();
      if ($urandom_range(0, 19) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   // Grass near a vertex, so the distance term is usually nonzero.
   function automatic logic [175:0] near_grass(input logic [31:0] cx, cy, cz);
      int spread;
      spread = 1 << $urandom_range(8, 20);
      return pack_item(cx + $urandom_range(0, spread) - spread / 2,
                       cy + $urandom_range(0, spread) - spread / 2,
                       cz + $urandom_range(0, spread) - spread / 2,
                       rand_norm(), rand_norm(), rand_norm(),
                       $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
   endfunction

   // Extremes, disabled occlusion, far grass, start with last, grass without start.
   task automatic test_directed();
      send_item(ACT_GRASS, pack_item(32'd1 << 16, 0, 0, 16'sd16384, 0, 0, 32'hFFFF_FFFF), 1);
      set_regs(32'h0001_0000, 32'h0001_0000, 16'd0, 16'd16384, 16'hFFFF);
      send_item(ACT_START, pack_item(0, 0, 0, 16'sd16384, 0, 0, 0), 1);
      send_item(ACT_START, pack_item(0, 0, 0, 16'sd16384, 0, 0, 0), 0);
      send_item(ACT_GRASS, pack_item(32'h0000_4000, 0, 0, 16'sd16384, 0, 0, 32'h0001_0000), 0);
      send_item(ACT_GRASS, pack_item(0, 32'h0000_8000, 0, 16'sd16384, 0, 0, 32'h0002_0000), 1);
      send_item(ACT_GRASS, pack_item(0, 0, 0, 16'sd16384, 0, 0, 32'hFFFF_FFFF), 1);
      send_item(ACT_START, pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     16'h8000, 16'h7FFF, 16'hC000, 32'hFFFF_FFFF), 0);
      send_item(ACT_GRASS, pack_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     16'h8000, 16'h7FFF, 16'hC000, 32'hFFFF_FFFF), 0);
      send_item(ACT_GRASS, pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     16'h8000, 16'h7FFF, 16'hC000, 32'hFFFF_FFFF), 0);
      send_item(ACT_GRASS, pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     16'h7FFF, 16'h8000, 16'h3FFF, 32'h1), 1);
      set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd32768, 16'd0, 16'd1);
      send_item(ACT_START, pack_item(0, 0, 0, 0, 16'sd16384, 0, 0), 0);
      send_item(ACT_GRASS, pack_item(0, 0, 0, 0, 16'sd16384, 0, 32'hFFFF_FFFF), 1);
      send_item(ACT_GRASS, pack_item(1, 0, 0, 0, -16'sd16384, 0, 32'hFFFF_FFFF), 1);
      set_regs(32'h0000_0001, 32'h0, 16'd100, 16'd200, 16'd300);
      send_item(ACT_START, pack_item(5, 6, 7, 0, 0, 16'sd16384, 7), 0);
      send_item(ACT_GRASS, pack_item(5, 6, 7, 0, 0, 16'sd16384, 32'h0001_0000), 1);
   endtask

   // Random queries under one register setting; returns once n_items are counted.
   task automatic test_random_queries(input int n_items);
      logic [31:0] cx, cy, cz;
      logic [175:0] d;
      int sent;
      sent = 0;
      cx = 0; cy = 0; cz = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            // Noise: arbitrary fields, random action and last.
            d = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            send_item(1'($urandom_range(0, 1)), d, 1'($urandom_range(0, 1)));
         end else begin
            cx = $urandom; cy = $urandom; cz = $urandom;
            d = pack_item(cx, cy, cz, rand_norm(), rand_norm(), rand_norm(), $urandom);
            send_item(ACT_START, d, $urandom_range(0, 15) == 0);
            repeat ($urandom_range(1, 8)) begin
               send_item(ACT_GRASS, near_grass(cx, cy, cz), $urandom_range(0, 9) == 0);
               sent++;
            end
            send_item(ACT_GRASS, near_grass(cx, cy, cz), 1);
         end
         sent += 2;
      end
   endtask

   task automatic test_random_settings();
      set_regs(32'h0000_0100, 32'h0000_1000, 16'd8000, 16'd16000, 16'd32000);
      test_random_queries(300);
      set_regs(32'h0004_0000, 32'h0001_0000, 16'd0, 16'd0, 16'd0);
      test_random_queries(300);
      set_regs($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
      test_random_queries(300);
      set_regs(32'h0000_0010, 32'h0100_0000, 16'd32768, 16'd12345, 16'd32767);
      test_random_queries(300);
      set_regs($urandom_range(1, 1 << 20), $urandom_range(1, 1 << 20),
               16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
               16'($urandom_range(0, 32768)));
      test_random_queries(200);
   endtask

   // Result side: random back-pressure, and a compare against the oldest prediction.
   initial begin
      int stall;
      shade_type exp_s, got_s;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 13);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got_s = rsp_tdata;
         if (shade_queue.size() == 0) begin
            $display("%0t: unexpected shade r=%0d g=%0d b=%0d", $time,
                     got_s.r, got_s.g, got_s.b);
            errors++;
         end else begin
            exp_s = shade_queue.pop_front();
            if (got_s.r !== exp_s.r) begin
               $display("%0t: shade_r expected %0d actual %0d", $time, exp_s.r, got_s.r);
               errors++;
            end
            if (got_s.g !== exp_s.g) begin
               $display("%0t: shade_g expected %0d actual %0d", $time, exp_s.g, got_s.g);
               errors++;
            end
            if (got_s.b !== exp_s.b) begin
               $display("%0t: shade_b expected %0d actual %0d", $time, exp_s.b, got_s.b);
               errors++;
            end
         end
      end
   end

   // Main sequence: reset, then the tests in turn, then drain and report.
   initial begin
      inv_radius_q = 0; inv_size_q = 0; ao_sum = 0;
      for (int i = 0; i < 3; i++) begin
         color_q[i] = 0; vtx_pos[i] = 0; vtx_norm[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_settings();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (shade_queue.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- grass_ambient_occlusion_accumulator_core.f -----
sv/gaoa_pkg.sv
sv/gaoa_isqrt.sv
sv/grass_ambient_occlusion_accumulator_core.sv
bench/tb_grass_ambient_occlusion_accumulator_core.sv
